// ===== rtl/core/pnguf_pkg.sv =====
// Shared types, constants and helper functions for the PNG scanline unfilter.
// Used by every module of the block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pnguf_pkg;

   // Row store geometry and image limits
   localparam int MAX_WIDTH    = 4096;
   localparam int ROW_BYTES    = 16384;
   localparam int COL_WIDTH    = $clog2(ROW_BYTES);
   localparam int STRIDE_WIDTH = COL_WIDTH + 1;
   localparam int WIDTH_BITS   = 13;
   localparam int HEIGHT_BITS  = 16;
   localparam int ROW_WIDTH    = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = QPTR_WIDTH + 1;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLOUR_LAYOUT = 2'd2;

   // Filter codes
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;
   localparam logic [7:0] FILT_MAX_BYTE = 8'd4;

   // Colour layouts (code is channel count minus one)
   localparam logic [1:0] LAYOUT_GREY       = 2'd0;
   localparam logic [1:0] LAYOUT_GREY_ALPHA = 2'd1;
   localparam logic [1:0] LAYOUT_RGB        = 2'd2;
   localparam logic [1:0] LAYOUT_RGBA       = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  image_width;
      logic [HEIGHT_BITS-1:0] image_height;
      logic [1:0]             colour_layout;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_FILTER,
      KIND_BAD,
      KIND_DATA
   } item_kind_type;

   // One classified word handed from front to back
   typedef struct packed {
      item_kind_type          kind;
      logic [7:0]             value;
      logic [COL_WIDTH-1:0]   col;
      logic [1:0]             chan;
      logic [1:0]             layout;
      logic [2:0]             filter;
      logic                   emit;
      logic                   final_px;
      logic                   first_row;
   } item_type;

   // Widest row in pixels that the store holds for a layout
   function automatic logic [WIDTH_BITS-1:0] width_limit(input logic [1:0] layout);
      int lim;
      case (layout)
         LAYOUT_GREY:       lim = ROW_BYTES / 1;
         LAYOUT_GREY_ALPHA: lim = ROW_BYTES / 2;
         LAYOUT_RGB:        lim = ROW_BYTES / 3;
         default:           lim = ROW_BYTES / 4;
      endcase
      if (lim > MAX_WIDTH) lim = MAX_WIDTH;
      return WIDTH_BITS'(lim);
   endfunction

   // Paeth predictor: nearest of a, b, c to a + b - c, ties to a then b
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [10:0]        pa;
      logic [10:0]        pb;
      logic [10:0]        pc;
      logic [7:0]         pick;
      da = $signed({3'b000, b}) - $signed({3'b000, c});
      db = $signed({3'b000, a}) - $signed({3'b000, c});
      dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
      pa = (da < 0) ? 11'(-da) : 11'(da);
      pb = (db < 0) ? 11'(-db) : 11'(db);
      pc = (dc < 0) ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) pick = a;
      else if (pb <= pc)        pick = b;
      else                      pick = c;
      return pick;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pnguf_front.sv =====
// Front end of the PNG unfilter: tracks row, column and filter state per input word
// and pushes classified words into the queue. Depends on pnguf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pnguf_pkg::cfg_type   cfg,
   input  wire logic                 req_valid,
   input  wire logic [7:0]           req_stream_byte,
   input  wire logic                 queue_full,
   output logic                      push,
   output pnguf_pkg::item_type       push_item
);

   logic [pnguf_pkg::COL_WIDTH-1:0]  col_ff, col_in;
   logic [1:0]                       mod3_ff, mod3_in;
   logic [pnguf_pkg::ROW_WIDTH-1:0]  row_ff, row_in;
   logic [2:0]                       filter_ff, filter_in;
   logic                             awaiting_ff, awaiting_in;
   logic                             error_ff, error_in;

   logic                                accept;
   logic [pnguf_pkg::WIDTH_BITS-1:0]    w_raw;
   logic [pnguf_pkg::WIDTH_BITS-1:0]    w_lim;
   logic [pnguf_pkg::WIDTH_BITS-1:0]    w_eff;
   logic [pnguf_pkg::HEIGHT_BITS-1:0]   h_eff;
   logic [2:0]                          ch;
   logic [pnguf_pkg::STRIDE_WIDTH-1:0]  stride;
   logic [pnguf_pkg::STRIDE_WIDTH-1:0]  col_next;
   logic [pnguf_pkg::ROW_WIDTH:0]       row_next;
   logic                                end_row;
   logic                                end_image;
   logic [1:0]                          chan;

   assign accept = req_valid && !queue_full;

   always_comb begin
      w_raw  = (cfg.image_width == '0) ? pnguf_pkg::WIDTH_BITS'(1) : cfg.image_width;
      w_lim  = pnguf_pkg::width_limit(cfg.colour_layout);
      w_eff  = (w_raw > w_lim) ? w_lim : w_raw;
      h_eff  = (cfg.image_height == '0) ? pnguf_pkg::HEIGHT_BITS'(1) : cfg.image_height;
      ch     = {1'b0, cfg.colour_layout} + 3'd1;
      stride = {2'b00, w_eff} * {12'd0, ch};
      col_next  = {1'b0, col_ff} + pnguf_pkg::STRIDE_WIDTH'(1);
      row_next  = {1'b0, row_ff} + 17'd1;
      end_row   = (col_next >= stride);
      end_image = end_row && (row_next >= {1'b0, h_eff});
      case (cfg.colour_layout)
         pnguf_pkg::LAYOUT_GREY:       chan = 2'd0;
         pnguf_pkg::LAYOUT_GREY_ALPHA: chan = {1'b0, col_ff[0]};
         pnguf_pkg::LAYOUT_RGB:        chan = mod3_ff;
         default:                      chan = col_ff[1:0];
      endcase
   end

   always_comb begin
      col_in      = col_ff;
      mod3_in     = mod3_ff;
      row_in      = row_ff;
      filter_in   = filter_ff;
      awaiting_in = awaiting_ff;
      error_in    = error_ff;
      push        = 1'b0;

      push_item           = '0;
      push_item.kind      = pnguf_pkg::KIND_DATA;
      push_item.value     = req_stream_byte;
      push_item.col       = col_ff;
      push_item.chan      = chan;
      push_item.layout    = cfg.colour_layout;
      push_item.filter    = filter_ff;
      push_item.emit      = (chan == cfg.colour_layout);
      push_item.final_px  = end_image;
      push_item.first_row = (row_ff == '0);

      if (accept) begin
         if (awaiting_ff) begin
            // filter word opens a row; swallowed while an error is latched
            awaiting_in = 1'b0;
            col_in      = '0;
            mod3_in     = 2'd0;
            if (!error_ff) begin
               push = 1'b1;
               if (req_stream_byte > pnguf_pkg::FILT_MAX_BYTE) begin
                  error_in       = 1'b1;
                  push_item.kind = pnguf_pkg::KIND_BAD;
               end else begin
                  filter_in      = req_stream_byte[2:0];
                  push_item.kind = pnguf_pkg::KIND_FILTER;
               end
            end
         end else begin
            push = !error_ff;
            if (end_row) begin
               col_in      = '0;
               mod3_in     = 2'd0;
               awaiting_in = 1'b1;
               if (end_image) begin
                  row_in   = '0;
                  error_in = 1'b0;
               end else begin
                  row_in = row_next[pnguf_pkg::ROW_WIDTH-1:0];
               end
            end else begin
               col_in  = col_next[pnguf_pkg::COL_WIDTH-1:0];
               mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         mod3_ff     <= 2'd0;
         row_ff      <= '0;
         filter_ff   <= pnguf_pkg::FILT_NONE;
         awaiting_ff <= 1'b1;
         error_ff    <= 1'b0;
      end else begin
         col_ff      <= col_in;
         mod3_ff     <= mod3_in;
         row_ff      <= row_in;
         filter_ff   <= filter_in;
         awaiting_ff <= awaiting_in;
         error_ff    <= error_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pnguf_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
// Depends on pnguf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pnguf_pkg::item_type  push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output pnguf_pkg::item_type       head_item
);

   pnguf_pkg::item_type entry_ff [pnguf_pkg::QUEUE_DEPTH];

   logic [pnguf_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pnguf_pkg::QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pnguf_pkg::QCNT_WIDTH-1:0] count_ff, count_in;

   assign full       = (count_ff == pnguf_pkg::QCNT_WIDTH'(pnguf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// ===== rtl/core/pnguf_back.sv =====
// Back end of the PNG unfilter: reads the row above, applies the predictor, updates
// the row store and neighbour bytes, and registers RGBA results. Depends on pnguf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire pnguf_pkg::item_type  head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [7:0]                rsp_alpha,
   output logic                      rsp_final_pixel,
   output logic                      rsp_bad_filter
);

   // row above, one byte per column
   logic [7:0] row_mem [pnguf_pkg::ROW_BYTES];

   logic                 r_valid_ff, r_valid_in;
   pnguf_pkg::item_type  r_item_ff;
   logic [7:0]           up_ff;

   logic [3:0][7:0] left_ff, left_in;
   logic [3:0][7:0] ul_ff, ul_in;
   logic [3:0][7:0] gather_ff, gather_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic [7:0]  red_in, green_in, blue_in, alpha_in;
   logic        final_ff, final_in;
   logic        bad_ff, bad_in;

   logic        out_free;
   logic        produces;
   logic        r_adv;
   logic        is_data;
   logic        wr_en;
   logic [7:0]  a;
   logic [7:0]  b;
   logic [7:0]  c;
   logic [8:0]  ab_sum;
   logic [7:0]  pred;
   logic [7:0]  v;

   always_comb begin
      is_data  = (r_item_ff.kind == pnguf_pkg::KIND_DATA);
      out_free = !out_valid_ff || !rsp_stall;
      produces = (r_item_ff.kind == pnguf_pkg::KIND_BAD) || (is_data && r_item_ff.emit);
      r_adv    = r_valid_ff && (!produces || out_free);
      pop      = head_valid && (!r_valid_ff || r_adv);
      wr_en    = r_adv && is_data;

      if (pop)        r_valid_in = 1'b1;
      else if (r_adv) r_valid_in = 1'b0;
      else            r_valid_in = r_valid_ff;
   end

   // predictor and reconstruction
   always_comb begin
      a      = left_ff[r_item_ff.chan];
      c      = ul_ff[r_item_ff.chan];
      b      = r_item_ff.first_row ? 8'd0 : up_ff;
      ab_sum = {1'b0, a} + {1'b0, b};
      case (r_item_ff.filter)
         pnguf_pkg::FILT_SUB:   pred = a;
         pnguf_pkg::FILT_UP:    pred = b;
         pnguf_pkg::FILT_AVG:   pred = ab_sum[8:1];
         pnguf_pkg::FILT_PAETH: pred = pnguf_pkg::paeth_pick(a, b, c);
         default:               pred = 8'd0;
      endcase
      v = r_item_ff.value + pred;
   end

   // neighbour bytes: clear on a row start, update a channel on data
   always_comb begin
      left_in   = left_ff;
      ul_in     = ul_ff;
      gather_in = gather_ff;
      if (r_adv) begin
         if (is_data) begin
            left_in[r_item_ff.chan]   = v;
            ul_in[r_item_ff.chan]     = b;
            gather_in[r_item_ff.chan] = v;
         end else begin
            left_in   = '0;
            ul_in     = '0;
            gather_in = '0;
         end
      end
   end

   // result formatting
   always_comb begin
      case (r_item_ff.layout)
         pnguf_pkg::LAYOUT_GREY: begin
            red_in   = gather_in[0];
            green_in = gather_in[0];
            blue_in  = gather_in[0];
            alpha_in = pnguf_pkg::ALPHA_OPAQUE;
         end
         pnguf_pkg::LAYOUT_GREY_ALPHA: begin
            red_in   = gather_in[0];
            green_in = gather_in[0];
            blue_in  = gather_in[0];
            alpha_in = gather_in[1];
         end
         pnguf_pkg::LAYOUT_RGB: begin
            red_in   = gather_in[0];
            green_in = gather_in[1];
            blue_in  = gather_in[2];
            alpha_in = pnguf_pkg::ALPHA_OPAQUE;
         end
         default: begin
            red_in   = gather_in[0];
            green_in = gather_in[1];
            blue_in  = gather_in[2];
            alpha_in = gather_in[3];
         end
      endcase
      final_in = r_item_ff.final_px;
      bad_in   = 1'b0;
      if (!is_data) begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
         alpha_in = 8'd0;
         final_in = 1'b0;
         bad_in   = 1'b1;
      end

      if (r_adv && produces) out_valid_in = 1'b1;
      else if (!rsp_stall)   out_valid_in = 1'b0;
      else                   out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         ul_ff        <= '0;
         gather_ff    <= '0;
      end else begin
         r_valid_ff   <= r_valid_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         ul_ff        <= ul_in;
         gather_ff    <= gather_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) r_item_ff <= head_item;
      if (r_adv && produces) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         final_ff <= final_in;
         bad_ff   <= bad_in;
      end
   end

   // row store: read at pop, write when a data word retires
   always_ff @(posedge clock) begin
      if (pop) up_ff <= row_mem[head_item.col];
      if (wr_en) row_mem[r_item_ff.col] <= v;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_alpha       = alpha_ff;
   assign rsp_final_pixel = final_ff;
   assign rsp_bad_filter  = bad_ff;

endmodule

`default_nettype wire

// ===== rtl/core/png_scanline_unfilter_rgba.sv =====
// Top level of the PNG scanline unfilter (8-bit, non-interlaced, RGBA out).
// Holds the configuration registers; instantiates pnguf_front, pnguf_queue, pnguf_back.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_stream_byte
//   rsp_      out        rsp_valid/rsp_stall   rsp_red, rsp_green, rsp_blue, rsp_alpha,
//                                              rsp_final_pixel, rsp_bad_filter
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One stream word per cycle, sustained while the queue is not full. A pixel's last byte is
// written into the queue, then popped by the back end as it reads the row store, and then
// run through the predictor into the result register; a stall can hold it between steps.
// Reset is synchronous; the row store needs no clearing pass since the first row of an
// image ignores what it reads. req_stall rises only when the four-word queue is full, and
// rsp_stall holds the result register and, once full, backs up into the queue.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_rgba (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // stream words in
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [7:0]                            req_stream_byte,
   // pixels out
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [7:0]                                 rsp_red,
   output logic [7:0]                                 rsp_green,
   output logic [7:0]                                 rsp_blue,
   output logic [7:0]                                 rsp_alpha,
   output logic                                       rsp_final_pixel,
   output logic                                       rsp_bad_filter,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pnguf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [pnguf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   pnguf_pkg::cfg_type  cfg_ff, cfg_in;

   logic                 queue_full;
   logic                 push;
   pnguf_pkg::item_type  push_item;
   logic                 pop;
   logic                 head_valid;
   pnguf_pkg::item_type  head_item;

   // Registers take writes at any time; software must write them only while the block is idle (unchecked).
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pnguf_pkg::REG_IMAGE_WIDTH:
               cfg_in.image_width = csr_wdata[pnguf_pkg::WIDTH_BITS-1:0];
            pnguf_pkg::REG_IMAGE_HEIGHT:
               cfg_in.image_height = csr_wdata[pnguf_pkg::HEIGHT_BITS-1:0];
            pnguf_pkg::REG_COLOUR_LAYOUT:
               cfg_in.colour_layout = csr_wdata[1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= pnguf_pkg::WIDTH_BITS'(1);
         cfg_ff.image_height  <= pnguf_pkg::HEIGHT_BITS'(1);
         cfg_ff.colour_layout <= pnguf_pkg::LAYOUT_RGBA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stall the stream only on a full queue, never on the result side directly.
   assign req_stall = queue_full;

   pnguf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stream_byte (req_stream_byte),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   pnguf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   pnguf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_final_pixel (rsp_final_pixel),
      .rsp_bad_filter  (rsp_bad_filter)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for png_scanline_unfilter_rgba: streams inflated rows,
// predicts every pixel in a model of the unfilter, and checks each result word.
// Depends on pnguf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
   import pnguf_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 20_000;
   localparam int RANDOM_WORDS  = 600;
   localparam int WIDE_WORDS    = 300;
   localparam int PRINT_LIMIT   = 30;
   localparam int HOLD_OFF      = 80;

   // Index 3 has no register behind it; writes there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       final_pixel;
      logic       bad_filter;
   } rgba_pixel_t;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Stream side
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_stream_byte = 8'h00;

   // Pixel side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_alpha;
   logic       rsp_final_pixel;
   logic       rsp_bad_filter;

   // Register port
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Configuration as the model sees it
   logic [WIDTH_BITS-1:0]  cfg_width  = WIDTH_BITS'(1);
   logic [HEIGHT_BITS-1:0] cfg_height = HEIGHT_BITS'(1);
   logic [1:0]             cfg_layout = LAYOUT_RGBA;

   // Unfilter model state
   logic [7:0]  upper_row [ROW_BYTES];
   logic [31:0] left_px     = '0;
   logic [31:0] upleft_px   = '0;
   logic [31:0] gather_px   = '0;
   int unsigned col_idx     = 0;
   int unsigned row_idx     = 0;
   logic [2:0]  row_filt    = FILT_NONE;
   bit          want_filter = 1'b1;
   bit          swallow     = 1'b0;

   rgba_pixel_t pending_pixels [$];

   // Run control and statistics
   bit req_idle_on       = 1'b1;
   bit rsp_idle_on       = 1'b1;
   int rsp_hold_request  = 0;
   int mismatches        = 0;
   int words_sent        = 0;
   int pixels_checked    = 0;
   int error_words       = 0;
   int images_done       = 0;
   int cycle_count       = 0;
   int input_held_cycles = 0;

   png_scanline_unfilter_rgba dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_final_pixel (rsp_final_pixel),
      .rsp_bad_filter  (rsp_bad_filter),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Model of the unfilter
   // ------------------------------------------------------------------

   // Pick whichever of left, up and upper-left lies nearest to left + up - upper-left;
   // ties go to left, then up.
   function automatic logic [7:0] paeth_nearest(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
      int est;
      int da;
      int db;
      int dc;
      est = int'(a) + int'(b) - int'(c);
      da  = est - int'(a);
      db  = est - int'(b);
      dc  = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // Advance the model by one accepted stream word; queue the pixel it completes.
   task automatic rebuild_byte(input logic [7:0] in_byte);
      int unsigned chans;
      int unsigned w;
      int unsigned h;
      int unsigned stride;
      int unsigned k;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  v;
      int          pred;
      bit          end_row;
      bit          end_image;
      rgba_pixel_t px;

      // Clamp the live geometry the way the block does
      chans = int'(cfg_layout) + 1;
      w     = cfg_width;
      h     = cfg_height;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (w > ROW_BYTES / chans) w = ROW_BYTES / chans;
      if (h == 0) h = 1;
      stride = w * chans;

      // Filter word: restart the row; an unknown code raises one error pixel
      if (want_filter) begin
         want_filter = 1'b0;
         col_idx     = 0;
         left_px     = '0;
         upleft_px   = '0;
         gather_px   = '0;
         if (!swallow) begin
            if (in_byte > FILT_MAX_BYTE) begin
               swallow = 1'b1;
               px = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
               pending_pixels.push_back(px);
            end else begin
               row_filt = in_byte[2:0];
            end
         end
         return;
      end

      end_row   = (col_idx + 1 >= stride);
      end_image = end_row && (row_idx + 1 >= h);

      if (!swallow) begin
         k = col_idx % chans;
         a = left_px[k*8 +: 8];
         c = upleft_px[k*8 +: 8];
         b = (row_idx > 0 && col_idx < ROW_BYTES) ? upper_row[col_idx] : 8'h00;
         case (row_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (int'(a) + int'(b)) >> 1;
            FILT_PAETH: pred = paeth_nearest(a, b, c);
            default:    pred = 0;
         endcase
         v = 8'(int'(in_byte) + pred);
         if (col_idx < ROW_BYTES) upper_row[col_idx] = v;
         left_px[k*8 +: 8]   = v;
         upleft_px[k*8 +: 8] = b;
         gather_px[k*8 +: 8] = v;
         if (k == chans - 1) begin
            case (cfg_layout)
               LAYOUT_GREY: begin
                  px.red   = gather_px[7:0];
                  px.green = gather_px[7:0];
                  px.blue  = gather_px[7:0];
                  px.alpha = ALPHA_OPAQUE;
               end
               LAYOUT_GREY_ALPHA: begin
                  px.red   = gather_px[7:0];
                  px.green = gather_px[7:0];
                  px.blue  = gather_px[7:0];
                  px.alpha = gather_px[15:8];
               end
               LAYOUT_RGB: begin
                  px.red   = gather_px[7:0];
                  px.green = gather_px[15:8];
                  px.blue  = gather_px[23:16];
                  px.alpha = ALPHA_OPAQUE;
               end
               default: begin
                  px.red   = gather_px[7:0];
                  px.green = gather_px[15:8];
                  px.blue  = gather_px[23:16];
                  px.alpha = gather_px[31:24];
               end
            endcase
            px.final_pixel = end_image;
            px.bad_filter  = 1'b0;
            pending_pixels.push_back(px);
         end
      end

      // Row and image bookkeeping runs even while an error swallows the image
      if (end_row) begin
         col_idx     = 0;
         want_filter = 1'b1;
         if (end_image) begin
            row_idx = 0;
            swallow = 1'b0;
         end else begin
            row_idx = (row_idx + 1) & 16'hFFFF;
         end
      end else begin
         col_idx = (col_idx + 1) & 15'h7FFF;
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one stream word after a random gap; hold it until taken, then predict.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(4, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      do @(posedge clock); while (req_stall);
      rebuild_byte(value);
      words_sent++;
   endtask

   // Write one register and leave csr_valid high; the caller drops it.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_IMAGE_WIDTH:   cfg_width  = data[WIDTH_BITS-1:0];
         REG_IMAGE_HEIGHT:  cfg_height = data[HEIGHT_BITS-1:0];
         REG_COLOUR_LAYOUT: cfg_layout = data[1:0];
         default: ;
      endcase
   endtask

   // Stop the stream, wait for every pending pixel, then let the pipeline empty
   // of words that produce nothing.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_WIDTH-1:0] width_data,
                             input logic [CSR_DATA_WIDTH-1:0] height_data,
                             input logic [CSR_DATA_WIDTH-1:0] layout_data);
      settle();
      write_reg(REG_IMAGE_WIDTH, width_data);
      write_reg(REG_IMAGE_HEIGHT, height_data);
      write_reg(REG_COLOUR_LAYOUT, layout_data);
      csr_valid <= 1'b0;
   endtask

   // Mostly small widths, now and then zero or a wider row; junk in unused bits.
   task automatic random_config();
      logic [WIDTH_BITS-1:0] w;
      case ($urandom_range(9, 0))
         0:       w = '0;
         1:       w = WIDTH_BITS'($urandom_range(64, 9));
         default: w = WIDTH_BITS'($urandom_range(8, 1));
      endcase
      set_config({3'($urandom), w}, 16'($urandom_range(6, 0)),
                 {14'($urandom), 2'($urandom)});
   endtask

   // Filter words are mostly legal; now and then an unknown code
   function automatic logic [7:0] pick_filter();
      if ($urandom_range(39, 0) == 0)
         return 8'($urandom_range(255, int'(FILT_MAX_BYTE) + 1));
      return 8'($urandom_range(FILT_PAETH, FILT_NONE));
   endfunction

   // Stream words until the model reaches the end of an image. With live_changes,
   // pause now and then mid-image and load a new configuration.
   task automatic stream_image(input bit live_changes);
      bit started;
      started = 1'b0;
      while (!(started && want_filter && row_idx == 0)) begin
         if (want_filter) send_byte(pick_filter());
         else send_byte(8'($urandom));
         started = 1'b1;
         if (live_changes && $urandom_range(63, 0) == 0) random_config();
      end
      images_done++;
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                  cycle_count, what, got, want);
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // Receiver: draw a stall for every pixel, or honor a long hold-off request
   initial begin : pixel_receiver
      int hold;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            hold = rsp_idle_on ? $urandom_range(4, 0) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare every accepted pixel word with the oldest prediction
   always @(posedge clock) begin : pixel_checker
      rgba_pixel_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("pixel word with nothing pending", 1, 0);
         end else begin
            want = pending_pixels.pop_front();
            check_field("red", rsp_red, want.red);
            check_field("green", rsp_green, want.green);
            check_field("blue", rsp_blue, want.blue);
            check_field("alpha", rsp_alpha, want.alpha);
            check_field("final_pixel", rsp_final_pixel, want.final_pixel);
            check_field("bad_filter", rsp_bad_filter, want.bad_filter);
            pixels_checked++;
            if (want.bad_filter) error_words++;
         end
      end
   end

   // Cycle budget and input backpressure count
   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && req_stall) input_held_cycles++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels pending",
                  cycle_count, pending_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: one RGBA pixel per image, one row
   task automatic test_reset_defaults();
      stream_image(1'b0);
      stream_image(1'b0);
   endtask

   // Width register saturated from all ones: a long first row must not end early.
   // A live shrink then closes the row and the image. The row also writes the store
   // well past any stride used later, so later rows never read an entry left unwritten.
   task automatic test_widest_row();
      set_config(16'hFFFF, 16'd1, {14'd0, LAYOUT_GREY});
      send_byte(8'(FILT_SUB));
      repeat (WIDE_WORDS) send_byte(8'($urandom));
      set_config(16'd1, 16'd1, {14'd0, LAYOUT_GREY});
      send_byte(8'($urandom));
      images_done++;
   endtask

   // Every filter on a grey-plus-alpha image, with sums that wrap and extreme bytes
   task automatic test_each_filter();
      logic [2:0] filt_seq [5] = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
      logic [7:0] data_seq [20] = '{8'hFF, 8'h00, 8'h80, 8'h7F,
                                    8'hFF, 8'h01, 8'hFF, 8'hFF,
                                    8'hFF, 8'hFF, 8'h00, 8'h01,
                                    8'hFF, 8'hFF, 8'h7F, 8'h80,
                                    8'h00, 8'hFF, 8'h55, 8'hAA};
      set_config(16'd2, 16'd5, {14'd0, LAYOUT_GREY_ALPHA});
      for (int r = 0; r < 5; r++) begin
         send_byte(8'(filt_seq[r]));
         for (int i = 0; i < 4; i++) send_byte(data_seq[r*4 + i]);
      end
      images_done++;
   endtask

   // Each colour layout on a small two-row image
   task automatic test_layouts();
      logic [1:0] layout_seq [4] = '{LAYOUT_GREY, LAYOUT_GREY_ALPHA, LAYOUT_RGB, LAYOUT_RGBA};
      foreach (layout_seq[i]) begin
         set_config(16'd3, 16'd2, {14'd0, layout_seq[i]});
         stream_image(1'b0);
      end
   endtask

   // Unknown filter on the first row, then on a later row; the next image is clean
   task automatic test_bad_filter();
      set_config(16'd2, 16'd3, {14'd0, LAYOUT_GREY});
      send_byte(8'hFF);
      stream_image(1'b0);
      send_byte(8'(FILT_SUB));
      send_byte(8'h10);
      send_byte(8'hF0);
      send_byte(FILT_MAX_BYTE + 8'd1);
      stream_image(1'b0);
      stream_image(1'b0);
   endtask

   // Zero width and height, the largest height cut short live, and the spare index
   task automatic test_size_extremes();
      set_config(16'd0, 16'd0, {14'd0, LAYOUT_GREY});
      stream_image(1'b0);
      set_config(16'd1, 16'hFFFF, {14'd0, LAYOUT_GREY});
      repeat (3) begin
         send_byte(8'(FILT_UP));
         send_byte(8'($urandom));
      end
      // Row counter is past the new height: the next row ends the image
      set_config(16'd2, 16'd2, {14'd0, LAYOUT_GREY_ALPHA});
      stream_image(1'b0);
      settle();
      write_reg(REG_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      stream_image(1'b0);
   endtask

   // Shrink the stride under a half-built pixel, then widen it mid-row
   task automatic test_live_reconfigure();
      set_config(16'd3, 16'd3, {14'd0, LAYOUT_RGBA});
      send_byte(8'(FILT_PAETH));
      repeat (5) send_byte(8'($urandom));
      set_config(16'd3, 16'd3, {14'd0, LAYOUT_GREY});
      send_byte(8'($urandom));
      send_byte(8'(FILT_AVG));
      send_byte(8'($urandom));
      set_config(16'd40, 16'd3, {14'd0, LAYOUT_RGB});
      stream_image(1'b0);
   endtask

   // Hold the pixel side off for a long stretch while words keep coming
   task automatic test_backpressure();
      set_config(16'd16, 16'd2, {14'd0, LAYOUT_RGBA});
      req_idle_on      = 1'b0;
      rsp_hold_request = HOLD_OFF;
      stream_image(1'b0);
      settle();
      req_idle_on = 1'b1;
   endtask

   // Random images with random idling, configurations and live changes
   task automatic test_random_images();
      int start;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         req_idle_on = ($urandom_range(3, 0) != 0);
         rsp_idle_on = ($urandom_range(3, 0) != 0);
         if ($urandom_range(1, 0) == 1) random_config();
         stream_image(1'b1);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin : run_tests
      int guard;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_widest_row();
      test_each_filter();
      test_layouts();
      test_bad_filter();
      test_size_extremes();
      test_live_reconfigure();
      test_backpressure();
      test_random_images();

      // Drain: wait for the last pixels, bounded, then give the pipeline time
      req_valid <= 1'b0;
      guard = 0;
      while (pending_pixels.size() > 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() > 0)
         report_mismatch("pixels never delivered", 0, pending_pixels.size());

      $display("ran %0d stream words over %0d images, checked %0d pixel words (%0d errors)",
               words_sent, images_done, pixels_checked, error_words);
      $display("input held off for %0d cycles, %0d mismatches in %0d cycles",
               input_held_cycles, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
